// ===== rtl/core/itda_pkg.sv =====
`default_nettype none

package itda_pkg;

    // default operand width
    localparam int DEF_WORD_WIDTH = 32;

    // width of the input value port
    localparam int VALUE_W = 32;

    // one bcd digit
    localparam int BCD_W = 4;

    // ascii codes
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;

    // controls broadcast to every digit cell
    typedef struct packed {
        logic clr;     // clear digit to zero
        logic dabble;  // add-3 correction then shift in carry from below
        logic shift;   // take the lower neighbor's digit
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== rtl/core/itda_cell.sv =====
`default_nettype none

module itda_cell (
    input  logic                          i_clk,
    input  itda_pkg::t_cell_ctl           i_ctl,
    input  logic                          i_carry,
    input  logic [itda_pkg::BCD_W-1:0]    i_digit_low,
    output logic                          o_carry,
    output logic [itda_pkg::BCD_W-1:0]    o_digit
);
    import itda_pkg::*;

    logic [BCD_W-1:0] r_digit;
    logic [BCD_W-1:0] n_digit;
    logic [BCD_W-1:0] adj;

    // add-3 correction of a digit at five or more
    assign adj = (r_digit >= BCD_W'(5)) ? r_digit + BCD_W'(3) : r_digit;

    // next digit per mode
    always_comb begin
        n_digit = r_digit;
        if (i_ctl.clr) begin
            n_digit = '0;
        end else if (i_ctl.dabble) begin
            n_digit = {adj[BCD_W-2:0], i_carry};
        end else if (i_ctl.shift) begin
            n_digit = i_digit_low;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_carry = adj[BCD_W-1];
    assign o_digit = r_digit;

endmodule

`default_nettype wire

// ===== rtl/core/int_to_decimal_ascii_top.sv =====
`default_nettype none

// channel   | direction | handshake        | beat payload
// ----------+-----------+------------------+------------------------------
// input     | in        | i_valid/o_stall  | i_value (signed 32)
// output    | out       | o_valid/i_stall  | o_character (8), o_last (1)
//
// one value goes through acceptance, double-dabble conversion in the
// digit-cell row, dropping of leading zeros, then emission of one character
// per cycle while the output is not stalled; leading zeros dropped and
// digits emitted add up to ND.
// a new value is taken only when the previous text has been handed to the
// output register; a stall holds the output beat and freezes emission.
// reset is synchronous and clears control state only.

module int_to_decimal_ascii_top #(
    parameter int WORD_WIDTH = itda_pkg::DEF_WORD_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [itda_pkg::VALUE_W-1:0] i_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [7:0]                          o_character,
    output logic                                o_last
);
    import itda_pkg::*;

    // digits needed for 2^(WORD_WIDTH-1)
    localparam int ND     = ((WORD_WIDTH - 1) * 30103) / 100000 + 1;
    localparam int CNT_W  = $clog2(WORD_WIDTH + 1);
    localparam int LEFT_W = $clog2(ND + 1);
    localparam int EXT_W  = (WORD_WIDTH > VALUE_W) ? WORD_WIDTH : VALUE_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_SKIP = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [LEFT_W-1:0]       r_left, n_left;
    logic [WORD_WIDTH-1:0]   r_mag, n_mag;
    logic                    r_neg, n_neg;
    logic                    r_sign_pend, n_sign_pend;
    logic                    r_ovalid, n_ovalid;
    logic [7:0]              r_char, n_char;
    logic                    r_last, n_last;

    logic signed [EXT_W-1:0] ext;
    logic [WORD_WIDTH-1:0]   raw;
    logic                    accept;
    logic                    slot_free;
    t_cell_ctl               ctl;
    logic [BCD_W-1:0]        dig   [ND];
    logic                    carry [ND];
    logic [BCD_W-1:0]        top_digit;

    // input value sign-extended, then cut to the working width
    assign ext       = EXT_W'(i_value);
    assign raw       = ext[WORD_WIDTH-1:0];
    assign accept    = i_valid && !o_stall;
    assign slot_free = !r_ovalid || !i_stall;
    assign top_digit = dig[ND-1];

    // row of bcd digit cells, cell 0 least significant
    for (genvar g = 0; g < ND; g++) begin : g_cell
        if (g == 0) begin : g_first
            itda_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (ctl),
                .i_carry     (r_mag[WORD_WIDTH-1]),
                .i_digit_low ('0),
                .o_carry     (carry[g]),
                .o_digit     (dig[g])
            );
        end else begin : g_rest
            itda_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (ctl),
                .i_carry     (carry[g-1]),
                .i_digit_low (dig[g-1]),
                .o_carry     (carry[g]),
                .o_digit     (dig[g])
            );
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_left      = r_left;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_sign_pend = r_sign_pend;
        n_ovalid    = r_ovalid;
        n_char      = r_char;
        n_last      = r_last;
        ctl         = '0;

        // output beat taken
        if (!i_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_neg       = raw[WORD_WIDTH-1];
                    n_sign_pend = raw[WORD_WIDTH-1];
                    n_mag       = raw[WORD_WIDTH-1] ? (~raw + 1'b1) : raw;
                    n_cnt       = CNT_W'(WORD_WIDTH);
                    ctl.clr     = 1'b1;
                    n_state     = S_CONV;
                end
            end
            S_CONV: begin
                // one magnitude bit into the cell row per cycle
                ctl.dabble = 1'b1;
                n_mag      = {r_mag[WORD_WIDTH-2:0], 1'b0};
                n_cnt      = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_left  = LEFT_W'(ND);
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                // drop leading zeros, keep at least one digit
                if (top_digit == '0 && r_left != LEFT_W'(1)) begin
                    ctl.shift = 1'b1;
                    n_left    = r_left - 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    if (r_sign_pend) begin
                        n_char      = CHAR_MINUS;
                        n_last      = 1'b0;
                        n_sign_pend = 1'b0;
                    end else begin
                        n_char    = CHAR_ZERO + 8'(top_digit);
                        n_last    = (r_left == LEFT_W'(1));
                        ctl.shift = 1'b1;
                        n_left    = r_left - 1'b1;
                        if (r_left == LEFT_W'(1)) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cnt       <= n_cnt;
        r_left      <= n_left;
        r_mag       <= n_mag;
        r_neg       <= n_neg;
        r_sign_pend <= n_sign_pend;
        r_char      <= n_char;
        r_last      <= n_last;
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_character = r_char;
    assign o_last      = r_last;

    // the top digit never overflows during conversion
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CONV |-> !carry[ND-1])
        else $error("digit row overflow");

    // a sign beat is never the final character
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_character == CHAR_MINUS |-> !o_last)
        else $error("sign marked last");

    // every character is a sign or a digit
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_character == CHAR_MINUS) ||
                    (o_character >= CHAR_ZERO && o_character <= CHAR_NINE))
        else $error("bad character");

    // a minus sign is pending only for negative values
    a_sign_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SKIP || r_state == S_EMIT) && r_sign_pend |-> r_neg)
        else $error("sign pending on positive value");

    // digit count stays nonzero while emitting
    a_left_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SKIP || r_state == S_EMIT) |-> r_left != '0)
        else $error("digit count ran out");

    // an accepted value starts conversion next cycle
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_state == S_CONV)
        else $error("conversion did not start");

endmodule

`default_nettype wire

// ===== tb/tb_int_to_decimal_ascii_top.sv =====
`default_nettype none

module tb_int_to_decimal_ascii_top;

    timeunit 1ns;
    timeprecision 1ps;

    import itda_pkg::*;

    localparam int NUM_RANDOM    = 310;
    localparam int CALM_TAIL     = 40;
    localparam int SEGMENT_LEN   = 200;
    localparam int MAX_BURST     = 11;
    localparam int SETTLE_CYCLES = 64;
    localparam int MAX_PRINTED   = 50;

    // one number waiting to be sent, optionally after the output has drained
    typedef struct {
        logic signed [VALUE_W-1:0] value;
        bit                        drain_first;
    } number_item_t;

    // one character beat of the decimal text
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_beat_t;

    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      in_valid    = 1'b0;
    logic signed [VALUE_W-1:0] in_value    = '0;
    logic                      out_stall   = 1'b0;
    logic                      in_stall;
    logic                      out_valid;
    logic [7:0]                out_character;
    logic                      out_last;

    number_item_t numbers_to_send[$];
    text_beat_t   text_expected[$];
    int           mismatch_count = 0;

    // sender idling state
    int send_gap_left  = 0;
    int send_gap_pct   = 0;
    int send_seg_count = 0;
    bit next_valid;

    // receiver stall state
    int stall_left      = 0;
    int stall_pct       = 0;
    int stall_seg_count = 0;

    int_to_decimal_ascii_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_stall     (in_stall),
        .i_value     (in_value),
        .o_valid     (out_valid),
        .i_stall     (out_stall),
        .o_character (out_character),
        .o_last      (out_last)
    );

    // clock
    initial begin
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED) begin
            $display("[%0t] error: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    // expected decimal text of one signed number, sign first
    function automatic void predict_decimal_text(input logic signed [VALUE_W-1:0] value);
        bit [VALUE_W-1:0] magnitude;
        logic [7:0]       digits[$];
        text_beat_t       beat;
        magnitude = value[VALUE_W-1] ? (~value + 1'b1) : value;
        do begin
            digits.push_front(CHAR_ZERO + 8'(magnitude % 10));
            magnitude = magnitude / 10;
        end while (magnitude != 0);
        if (value[VALUE_W-1]) begin
            beat.ch   = CHAR_MINUS;
            beat.last = 1'b0;
            text_expected.push_back(beat);
        end
        foreach (digits[i]) begin
            beat.ch   = digits[i];
            beat.last = (i == digits.size() - 1);
            text_expected.push_back(beat);
        end
    endfunction

    function automatic longint ten_to(input int k);
        longint p;
        p = 1;
        repeat (k) p = p * 10;
        return p;
    endfunction

    task automatic queue_number(input logic signed [VALUE_W-1:0] value, input bit drain);
        number_item_t item;
        item.value       = value;
        item.drain_first = drain;
        numbers_to_send.push_back(item);
    endtask

    // random number, biased toward every digit count and decade edges
    function automatic logic signed [VALUE_W-1:0] random_number();
        bit     negative;
        int     k;
        longint lo;
        longint hi;
        longint magnitude;
        negative = $urandom_range(0, 1);
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: begin
                k  = $urandom_range(1, 10);
                lo = (k == 1) ? 0 : ten_to(k - 1);
                hi = ten_to(k) - 1;
                if (negative && hi > 64'd2147483648) hi = 64'd2147483648;
                if (!negative && hi > 64'd2147483647) hi = 64'd2147483647;
                magnitude = lo + longint'($urandom) % (hi - lo + 1);
            end
            2: begin
                k = $urandom_range(1, 9);
                magnitude = ten_to(k) + $urandom_range(0, 2) - 1;
            end
            default: magnitude = $urandom_range(0, 20);
        endcase
        return VALUE_W'(negative ? -magnitude : magnitude);
    endfunction

    // sender: valid holds until the beat is taken
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid      <= 1'b0;
            send_gap_left = 0;
        end else begin
            if (in_valid && !in_stall) begin
                predict_decimal_text(in_value);
            end
            if (in_valid && in_stall) begin
                next_valid = 1'b1;
            end else begin
                next_valid = 1'b0;
                if (++send_seg_count >= SEGMENT_LEN) begin
                    send_seg_count = 0;
                    case ($urandom_range(0, 2))
                        0: send_gap_pct = 0;
                        1: send_gap_pct = 15;
                        default: send_gap_pct = 45;
                    endcase
                end
                if (numbers_to_send.size() < CALM_TAIL) begin
                    send_gap_left = 0;
                end
                if (send_gap_left > 0) begin
                    send_gap_left--;
                end else if (numbers_to_send.size() != 0) begin
                    if (numbers_to_send[0].drain_first && text_expected.size() != 0) begin
                        // hold off until the whole text so far has been read
                    end else if (numbers_to_send.size() >= CALM_TAIL &&
                                 $urandom_range(0, 99) < send_gap_pct) begin
                        send_gap_left = $urandom_range(1, MAX_BURST) - 1;
                    end else begin
                        in_value   <= numbers_to_send[0].value;
                        next_valid = 1'b1;
                        void'(numbers_to_send.pop_front());
                    end
                end
            end
            in_valid <= next_valid;
        end
    end

    // receiver: check each taken beat, then pick the next stall
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (text_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected character %h last %b",
                                              out_character, out_last));
                end else begin
                    if (out_character !== text_expected[0].ch) begin
                        report_mismatch($sformatf("character %h, expected %h",
                                                  out_character, text_expected[0].ch));
                    end
                    if (out_last !== text_expected[0].last) begin
                        report_mismatch($sformatf("last %b, expected %b on character %h",
                                                  out_last, text_expected[0].last,
                                                  text_expected[0].ch));
                    end
                    void'(text_expected.pop_front());
                end
            end
            if (++stall_seg_count >= SEGMENT_LEN) begin
                stall_seg_count = 0;
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 15;
                    default: stall_pct = 40;
                endcase
            end
            if (numbers_to_send.size() < CALM_TAIL) begin
                stall_left = 0;
                out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(1, MAX_BURST) - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // stimulus and end of run
    initial begin
        // extremes, decade edges and sign cases
        queue_number(32'sd0, 1'b0);
        queue_number(32'sd1, 1'b0);
        queue_number(-32'sd1, 1'b0);
        queue_number(32'sd9, 1'b0);
        queue_number(32'sd10, 1'b0);
        queue_number(-32'sd10, 1'b0);
        queue_number(32'sd99, 1'b0);
        queue_number(32'sd100, 1'b0);
        queue_number(-32'sd7, 1'b0);
        queue_number(32'sd2147483647, 1'b0);
        queue_number(32'sh8000_0000, 1'b0);
        queue_number(-32'sd2147483647, 1'b0);
        queue_number(32'sd1000000000, 1'b0);
        queue_number(32'sd999999999, 1'b0);
        queue_number(-32'sd999999999, 1'b0);
        queue_number(-32'sd1000000000, 1'b0);
        queue_number(32'sd123456789, 1'b0);
        queue_number(32'sh5555_5555, 1'b0);
        queue_number(32'shAAAA_AAAA, 1'b0);
        queue_number(32'sd0, 1'b0);
        // random part, draining first and now and then
        for (int n = 0; n < NUM_RANDOM; n++) begin
            queue_number(random_number(), n == 0 || $urandom_range(0, 99) < 2);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (numbers_to_send.size() != 0 || in_valid) @(posedge clk);
        while (text_expected.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // watchdog
    initial begin
        #1000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
